// File: src/iscs_pkg.sv
// ============================================================================
// iscs_pkg
// Shared types, constants and arithmetic helpers for the IMU sample
// conditioning and shock detection block.
// ============================================================================
package iscs_pkg;

    // Field widths.
    localparam int unsigned RAW_W    = 16;  // raw sensor count
    localparam int unsigned OUT_W    = 32;  // Q15.16 result
    localparam int unsigned THR_W    = 31;  // shock threshold register
    localparam int unsigned RANGES_W = 6;   // packed range codes
    localparam int unsigned CFG_IDX_W = 3;  // configuration register index

    // Accel scaling is an exact left shift: 65536 / 8192 = 2^3 for the
    // smallest range, one more bit for each range step.
    localparam int unsigned ACC_SHIFT_BASE = 3;
    localparam int unsigned ACC_W          = 23; // holds +/-2^21 after negation

    // Gyro and mag scaling multiply the magnitude by a fixed-point reciprocal
    // with FRAC_K fraction bits and round at the binary point.
    localparam int unsigned FRAC_K   = 32;
    localparam int unsigned RECIP_W  = 46;
    localparam int unsigned PROD_W   = 62;
    localparam int unsigned MAG_W    = 29;  // rounded magnitude, below 2^28
    localparam int unsigned SCALED_W = MAG_W + 1;
    localparam int unsigned DIFF_W   = OUT_W + 2;

    // Shock test widths.
    localparam int unsigned DEV_W  = 26;    // 3*new - sum of three entries
    localparam int unsigned THR3_W = THR_W + 2;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_K - 1));

    // Gyro: 10 * 65536 over the sensitivity in tenths of a count per dps.
    localparam logic [RECIP_W-1:0] GYRO_RECIP [4] = '{
        RECIP_W'((64'd655360 << FRAC_K) / 64'd655),
        RECIP_W'((64'd655360 << FRAC_K) / 64'd328),
        RECIP_W'((64'd655360 << FRAC_K) / 64'd164),
        RECIP_W'((64'd655360 << FRAC_K) / 64'd82)
    };

    // Mag: 65536 over the sensitivity in counts per gauss.
    localparam logic [RECIP_W-1:0] MAG_RECIP [4] = '{
        RECIP_W'((64'd65536 << FRAC_K) / 64'd6842),
        RECIP_W'((64'd65536 << FRAC_K) / 64'd3421),
        RECIP_W'((64'd65536 << FRAC_K) / 64'd2281),
        RECIP_W'((64'd65536 << FRAC_K) / 64'd1711)
    };

    localparam logic [RANGES_W-1:0] RANGES_RESET = RANGES_W'(3);

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_RANGES   = 3'd0,
        CFG_SHOCK_THRESHOLD = 3'd1,
        CFG_GYRO_OFFSET_X   = 3'd2,
        CFG_GYRO_OFFSET_Y   = 3'd3,
        CFG_GYRO_OFFSET_Z   = 3'd4,
        CFG_MAG_OFFSET_X    = 3'd5,
        CFG_MAG_OFFSET_Y    = 3'd6,
        CFG_MAG_OFFSET_Z    = 3'd7
    } cfg_reg_t;

    // One raw nine-axis sample.
    typedef struct packed {
        logic signed [RAW_W-1:0] raw_acc_x;
        logic signed [RAW_W-1:0] raw_acc_y;
        logic signed [RAW_W-1:0] raw_acc_z;
        logic signed [RAW_W-1:0] raw_gyro_x;
        logic signed [RAW_W-1:0] raw_gyro_y;
        logic signed [RAW_W-1:0] raw_gyro_z;
        logic signed [RAW_W-1:0] raw_mag_x;
        logic signed [RAW_W-1:0] raw_mag_y;
        logic signed [RAW_W-1:0] raw_mag_z;
    } raw_sample_t;

    // One conditioned board-frame sample.
    typedef struct packed {
        logic signed [OUT_W-1:0] acc_x;
        logic signed [OUT_W-1:0] acc_y;
        logic signed [OUT_W-1:0] acc_z;
        logic signed [OUT_W-1:0] gyro_x;
        logic signed [OUT_W-1:0] gyro_y;
        logic signed [OUT_W-1:0] gyro_z;
        logic signed [OUT_W-1:0] mag_x;
        logic signed [OUT_W-1:0] mag_y;
        logic signed [OUT_W-1:0] mag_z;
        logic                    shock;
    } imu_result_t;

    // Accel count to Q15.16: a left shift chosen by the range code.
    function automatic logic signed [ACC_W-1:0] acc_scale(
        input logic signed [RAW_W-1:0] raw,
        input logic [1:0]              code
    );
        logic signed [ACC_W-1:0] ext;
        ext = ACC_W'(raw);
        return ext <<< (ACC_SHIFT_BASE + 32'(code));
    endfunction

    // Count times reciprocal, rounded to nearest on the magnitude so that
    // halves would go away from zero, sign restored afterwards.
    function automatic logic signed [SCALED_W-1:0] scale_round(
        input logic signed [RAW_W-1:0] raw,
        input logic [RECIP_W-1:0]      recip
    );
        logic [RAW_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  q;
        logic signed [SCALED_W-1:0] qs;
        mag  = raw[RAW_W-1] ? (~raw + RAW_W'(1)) : raw;
        prod = PROD_W'(mag) * PROD_W'(recip) + ROUND_HALF;
        q    = prod[FRAC_K +: MAG_W];
        qs   = signed'({1'b0, q});
        return raw[RAW_W-1] ? -qs : qs;
    endfunction

    // Subtract an offset and clamp to the 32-bit range.
    function automatic logic signed [OUT_W-1:0] sub_sat(
        input logic signed [SCALED_W-1:0] v,
        input logic signed [OUT_W-1:0]    off
    );
        logic signed [DIFF_W-1:0] diff;
        diff = DIFF_W'(v) - DIFF_W'(off);
        if (diff[DIFF_W-1:OUT_W-1] == '0 || diff[DIFF_W-1:OUT_W-1] == '1)
            return diff[OUT_W-1:0];
        else if (diff[DIFF_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    // True when |3*v - (h0 + h1 + h2)| exceeds three times the threshold.
    function automatic logic deviates(
        input logic signed [ACC_W-1:0] h0,
        input logic signed [ACC_W-1:0] h1,
        input logic signed [ACC_W-1:0] h2,
        input logic signed [ACC_W-1:0] v,
        input logic [THR3_W-1:0]       thr3
    );
        logic signed [DEV_W-1:0] d;
        logic [DEV_W-1:0]        mag;
        d   = DEV_W'(v) + DEV_W'(v) + DEV_W'(v) - (DEV_W'(h0) + DEV_W'(h1) + DEV_W'(h2));
        mag = d[DEV_W-1] ? (~d + DEV_W'(1)) : d;
        return THR3_W'(mag) > thr3;
    endfunction

endpackage

// File: src/imu_sample_condition_shock_unit.sv
// ============================================================================
// imu_sample_condition_shock_unit
// Scales a raw nine-axis IMU sample to Q15.16, remaps it to the board frame,
// removes gyro and mag offsets and flags accel shocks against a short history.
// ============================================================================
// A beat accepted into the input register moves on into the result register once
// the output can advance, and out_valid rises as the result register is loaded.
// Throughput: one beat per cycle unless out_stall holds a full result register; accel
// scales by a shift and each gyro and mag axis has its own reciprocal multiplier between the two registers.
// Reset: clears both valid flags and the accel history (zeros count as three samples),
// sets the range codes to accel 3, gyro 0, mag 0 and the threshold and offsets to zero.
module imu_sample_condition_shock_unit
    import iscs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [OUT_W-1:0]            cfg_data,

    // Raw sample channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [RAW_W-1:0]     raw_acc_x,
    input  logic signed [RAW_W-1:0]     raw_acc_y,
    input  logic signed [RAW_W-1:0]     raw_acc_z,
    input  logic signed [RAW_W-1:0]     raw_gyro_x,
    input  logic signed [RAW_W-1:0]     raw_gyro_y,
    input  logic signed [RAW_W-1:0]     raw_gyro_z,
    input  logic signed [RAW_W-1:0]     raw_mag_x,
    input  logic signed [RAW_W-1:0]     raw_mag_y,
    input  logic signed [RAW_W-1:0]     raw_mag_z,

    // Conditioned sample channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_W-1:0]     acc_x,
    output logic signed [OUT_W-1:0]     acc_y,
    output logic signed [OUT_W-1:0]     acc_z,
    output logic signed [OUT_W-1:0]     gyro_x,
    output logic signed [OUT_W-1:0]     gyro_y,
    output logic signed [OUT_W-1:0]     gyro_z,
    output logic signed [OUT_W-1:0]     mag_x,
    output logic signed [OUT_W-1:0]     mag_y,
    output logic signed [OUT_W-1:0]     mag_z,
    output logic                        shock
);

    // Configuration registers.
    logic [RANGES_W-1:0]     ranges_reg;
    logic [THR3_W-1:0]       thr3_reg;
    logic signed [OUT_W-1:0] gyro_off_reg [3];
    logic signed [OUT_W-1:0] mag_off_reg [3];

    // Pipeline registers.
    logic        in_valid_reg;
    logic        in_valid_next;
    raw_sample_t in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    imu_result_t res_reg;
    imu_result_t res_next;

    // Accel history, oldest entry first.
    logic signed [ACC_W-1:0] hist_x_reg [3];
    logic signed [ACC_W-1:0] hist_y_reg [3];
    logic signed [ACC_W-1:0] hist_z_reg [3];

    logic in_accept;
    logic out_advance;

    // Scaled axes of the sample in the input register.
    logic signed [ACC_W-1:0]    acc_bx;
    logic signed [ACC_W-1:0]    acc_by;
    logic signed [ACC_W-1:0]    acc_bz;
    logic signed [SCALED_W-1:0] gyro_sx;
    logic signed [SCALED_W-1:0] gyro_sy;
    logic signed [SCALED_W-1:0] gyro_sz;
    logic signed [SCALED_W-1:0] mag_sx;
    logic signed [SCALED_W-1:0] mag_sy;
    logic signed [SCALED_W-1:0] mag_sz;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ranges_reg   <= RANGES_RESET;
            thr3_reg     <= '0;
            gyro_off_reg <= '{default: '0};
            mag_off_reg  <= '{default: '0};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SENSOR_RANGES:   ranges_reg      <= cfg_data[RANGES_W-1:0];
                CFG_SHOCK_THRESHOLD: thr3_reg        <= THR3_W'(cfg_data[THR_W-1:0]) * THR3_W'(3);
                CFG_GYRO_OFFSET_X:   gyro_off_reg[0] <= cfg_data;
                CFG_GYRO_OFFSET_Y:   gyro_off_reg[1] <= cfg_data;
                CFG_GYRO_OFFSET_Z:   gyro_off_reg[2] <= cfg_data;
                CFG_MAG_OFFSET_X:    mag_off_reg[0]  <= cfg_data;
                CFG_MAG_OFFSET_Y:    mag_off_reg[1]  <= cfg_data;
                CFG_MAG_OFFSET_Z:    mag_off_reg[2]  <= cfg_data;
            endcase
        end
    end

    // Handshake: the result register drains or refills, the input register
    // refills whenever it is empty or moving on.
    assign out_advance = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = in_valid_reg && !out_advance;
    assign in_accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (out_advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register for the raw beat.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg.raw_acc_x  <= raw_acc_x;
            in_data_reg.raw_acc_y  <= raw_acc_y;
            in_data_reg.raw_acc_z  <= raw_acc_z;
            in_data_reg.raw_gyro_x <= raw_gyro_x;
            in_data_reg.raw_gyro_y <= raw_gyro_y;
            in_data_reg.raw_gyro_z <= raw_gyro_z;
            in_data_reg.raw_mag_x  <= raw_mag_x;
            in_data_reg.raw_mag_y  <= raw_mag_y;
            in_data_reg.raw_mag_z  <= raw_mag_z;
        end
    end

    // Scaling and board-frame remap. Range codes: accel in bits 1:0,
    // gyro in bits 3:2, mag in bits 5:4.
    assign acc_bx = -acc_scale(in_data_reg.raw_acc_y, ranges_reg[1:0]);
    assign acc_by = acc_scale(in_data_reg.raw_acc_x, ranges_reg[1:0]);
    assign acc_bz = acc_scale(in_data_reg.raw_acc_z, ranges_reg[1:0]);

    assign gyro_sx = scale_round(in_data_reg.raw_gyro_x, GYRO_RECIP[ranges_reg[3:2]]);
    assign gyro_sy = scale_round(in_data_reg.raw_gyro_y, GYRO_RECIP[ranges_reg[3:2]]);
    assign gyro_sz = scale_round(in_data_reg.raw_gyro_z, GYRO_RECIP[ranges_reg[3:2]]);

    assign mag_sx = scale_round(in_data_reg.raw_mag_x, MAG_RECIP[ranges_reg[5:4]]);
    assign mag_sy = scale_round(in_data_reg.raw_mag_y, MAG_RECIP[ranges_reg[5:4]]);
    assign mag_sz = scale_round(in_data_reg.raw_mag_z, MAG_RECIP[ranges_reg[5:4]]);

    // Offset removal, saturation and the shock test against the history.
    always_comb
    begin
        res_next.acc_x  = OUT_W'(acc_bx);
        res_next.acc_y  = OUT_W'(acc_by);
        res_next.acc_z  = OUT_W'(acc_bz);
        res_next.gyro_x = sub_sat(-gyro_sy, gyro_off_reg[0]);
        res_next.gyro_y = sub_sat(gyro_sx, gyro_off_reg[1]);
        res_next.gyro_z = sub_sat(gyro_sz, gyro_off_reg[2]);
        res_next.mag_x  = sub_sat(mag_sy, mag_off_reg[0]);
        res_next.mag_y  = sub_sat(-mag_sx, mag_off_reg[1]);
        res_next.mag_z  = sub_sat(mag_sz, mag_off_reg[2]);
        res_next.shock  =
            deviates(hist_x_reg[0], hist_x_reg[1], hist_x_reg[2], acc_bx, thr3_reg) ||
            deviates(hist_y_reg[0], hist_y_reg[1], hist_y_reg[2], acc_by, thr3_reg) ||
            deviates(hist_z_reg[0], hist_z_reg[1], hist_z_reg[2], acc_bz, thr3_reg);
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (out_advance)
            res_reg <= res_next;
    end

    // History shifts as each beat moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_x_reg <= '{default: '0};
            hist_y_reg <= '{default: '0};
            hist_z_reg <= '{default: '0};
        end
        else if (out_advance)
        begin
            hist_x_reg <= '{hist_x_reg[1], hist_x_reg[2], acc_bx};
            hist_y_reg <= '{hist_y_reg[1], hist_y_reg[2], acc_by};
            hist_z_reg <= '{hist_z_reg[1], hist_z_reg[2], acc_bz};
        end
    end

    // Output ports.
    assign out_valid = out_valid_reg;
    assign acc_x     = res_reg.acc_x;
    assign acc_y     = res_reg.acc_y;
    assign acc_z     = res_reg.acc_z;
    assign gyro_x    = res_reg.gyro_x;
    assign gyro_y    = res_reg.gyro_y;
    assign gyro_z    = res_reg.gyro_z;
    assign mag_x     = res_reg.mag_x;
    assign mag_y     = res_reg.mag_y;
    assign mag_z     = res_reg.mag_z;
    assign shock     = res_reg.shock;

    // The input side only stalls while a beat sits in the input register.
    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    // A beat moving on always shows up on the output.
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_advance |=> out_valid_reg)
        else $error("advanced beat not presented at the output");

    // The newest history entries match the accel result just loaded.
    a_history_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_advance |=> (acc_x == OUT_W'(hist_x_reg[2]) &&
                         acc_y == OUT_W'(hist_y_reg[2]) &&
                         acc_z == OUT_W'(hist_z_reg[2])))
        else $error("accel history out of step with the result register");

endmodule
